// File: sv/esp_pkg.sv
// shared types, constants and register codes of the engine sound pitch modulator
package esp_pkg;

  // modulation channel count, acts as at most four (only four draw fields)
  localparam int MOD_CHANNELS = 4;
  localparam int CH_LIMIT     = 4;
  localparam int CH_COUNT     = (MOD_CHANNELS > CH_LIMIT) ? CH_LIMIT :
                                (MOD_CHANNELS < 1) ? 1 : MOD_CHANNELS;
  localparam int CH_IDX_W     = (CH_COUNT > 1) ? $clog2(CH_COUNT) : 1;

  // field widths
  localparam int DRAW_W      = 15;
  localparam int DRAWS_W     = 3 * DRAW_W;
  localparam int IN_TDATA_W  = ((CH_LIMIT * DRAWS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 3;
  localparam int SLOT_W      = 3;
  localparam int PITCH_W     = 16;
  localparam int VOL_W       = 16;
  localparam int PAN_W       = 7;
  localparam int STEP_W      = 11;
  localparam int OUT_TDATA_W = ((PITCH_W + VOL_W + PAN_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // remainder unit: 16-bit quotient path, four bits retired per cycle
  localparam int DIV_W      = 16;
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // fixed values
  localparam logic [PITCH_W-1:0] PITCH_MAX   = 16'hFFFF;
  localparam logic [VOL_W-1:0]   MAIN_VOLUME = 16'h5AAA;
  localparam logic [PAN_W-1:0]   MAIN_PAN    = 7'h40;
  localparam logic [DIV_W-1:0]   PAN_SPAN    = 16'h0041;

  // reset values of state
  localparam logic [PITCH_W-1:0] RST_MAIN_PITCH = 16'h2000;
  localparam logic [PITCH_W-1:0] RST_MOD_PITCH  = 16'hC000;
  localparam logic [STEP_W-1:0]  RST_MOD_STEP   = 11'd80;
  localparam logic [VOL_W-1:0]   RST_MOD_VOLUME = 16'h2AAA;
  localparam logic [PAN_W-1:0]   RST_MOD_PAN    = 7'h40;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RAMP_STEP      = 3'd0,
    CFG_PITCH_FLOOR    = 3'd1,
    CFG_TURN_THRESHOLD = 3'd2,
    CFG_STEP_MIN       = 3'd3,
    CFG_STEP_SPAN      = 3'd4,
    CFG_VOLUME_MIN     = 3'd5,
    CFG_VOLUME_SPAN    = 3'd6,
    CFG_PAN_MIN        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] ramp_step;
    logic [15:0] pitch_floor;
    logic [15:0] turn_threshold;
    logic [7:0]  step_min;
    logic [8:0]  step_span;
    logic [15:0] volume_min;
    logic [15:0] volume_span;
    logic [5:0]  pan_min;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ramp_step:      16'd592,
    pitch_floor:    16'd8192,
    turn_threshold: 16'd49152,
    step_min:       8'd80,
    step_span:      9'd433,
    volume_min:     16'd10922,
    volume_span:    16'd8193,
    pan_min:        6'd32
  };

  // remainder unit request and response
  typedef struct packed {
    logic              start;
    logic [DRAW_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } rem_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAIN,
    S_CH_EVAL,
    S_REM,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    REM_STEP,
    REM_VOL,
    REM_PAN
  } rem_sel_t;

endpackage

// File: sv/esp_cfg_regs.sv
// configuration register file of the engine sound pitch modulator
module esp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [esp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [esp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output esp_pkg::cfg_t                    cfg
);

  esp_pkg::cfg_t cfg_r;
  esp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        esp_pkg::CFG_RAMP_STEP:      cfg_nxt.ramp_step      = cfg_wdata;
        esp_pkg::CFG_PITCH_FLOOR:    cfg_nxt.pitch_floor    = cfg_wdata;
        esp_pkg::CFG_TURN_THRESHOLD: cfg_nxt.turn_threshold = cfg_wdata;
        esp_pkg::CFG_STEP_MIN:       cfg_nxt.step_min       = cfg_wdata[7:0];
        esp_pkg::CFG_STEP_SPAN:      cfg_nxt.step_span      = cfg_wdata[8:0];
        esp_pkg::CFG_VOLUME_MIN:     cfg_nxt.volume_min     = cfg_wdata;
        esp_pkg::CFG_VOLUME_SPAN:    cfg_nxt.volume_span    = cfg_wdata;
        esp_pkg::CFG_PAN_MIN:        cfg_nxt.pan_min        = cfg_wdata[5:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= esp_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/esp_rem_unit.sv
// shared iterative remainder unit, four restoring steps per cycle
module esp_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  esp_pkg::rem_req_t req,
  output esp_pkg::rem_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [esp_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [esp_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [esp_pkg::DIV_W-1:0]       rem_r, rem_nxt;
  logic [esp_pkg::DIV_W-1:0]       div_r, div_nxt;
  logic [esp_pkg::DIV_W:0]         part;
  logic [esp_pkg::DIV_W-1:0]       shq;

  always_comb begin
    part = {1'b0, rem_r};
    shq  = quo_r;
    for (int i = 0; i < esp_pkg::DIV_BITS; i++) begin
      part = {part[esp_pkg::DIV_W-1:0], shq[esp_pkg::DIV_W-1]};
      shq  = {shq[esp_pkg::DIV_W-2:0], 1'b0};
      if (part >= {1'b0, div_r}) begin
        part = part - {1'b0, div_r};
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = esp_pkg::DIV_W'(req.dividend);
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = shq;
      rem_nxt = part[esp_pkg::DIV_W-1:0];
      cnt_nxt = cnt_r + esp_pkg::DIV_CNT_W'(1);
      if (cnt_r == esp_pkg::DIV_CNT_W'(esp_pkg::DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // a zero modulus gives a zero remainder
  assign rsp.done = done_r;
  assign rsp.rem  = (div_r == '0) ? '0 : rem_r;

endmodule

// File: sv/engine_sound_pitch_modulator.sv
// top level of the engine sound pitch modulator: sequencer, voice state, output register
//
// usage
//   in_*  : one item per frame tick. in_tuser holds the enable and accelerate flags,
//           in_tdata the raw 15-bit draws of the four modulation channels.
//   out_* : voice updates, slot 0 (main voice) first, then one per channel;
//           out_tlast marks the final update of the tick.
//   cfg_* : register writes on cfg_wr_en high, only while idle: a user rule, unchecked.
// flow
//   in_tready is high only while the sequencer is idle; a tick with either enable
//   flag low is taken there and gives no update. An enabled tick runs the main
//   update and its emit, then for each channel an evaluation, the remainders it
//   needs (none with no turn, one for a turn down, three for a turn up, all from
//   the one remainder unit) and an emit.
// reset
//   synchronous, active low: registers and voice state return to their reset values
//   at once, no clearing pass.
// stall
//   a single output register holds the pending update; while it is full and out_tready
//   is low, the sequencer waits in its emit step.
module engine_sound_pitch_modulator (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: draws_ch0 [44:0], draws_ch1 [89:45], draws_ch2 [134:90],
  //           draws_ch3 [179:135], zero fill [183:180]
  input  logic [esp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: audio_ready [0], engine_sound_on [1], accelerating [2]
  input  logic [esp_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: pitch [15:0], volume [31:16], pan [38:32], zero fill [39]
  output logic [esp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: voice_slot [2:0]
  output logic [esp_pkg::SLOT_W-1:0]         out_tuser,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wr_en,
  input  logic [esp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [esp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NCH  = esp_pkg::CH_COUNT;
  localparam int IDXW = esp_pkg::CH_IDX_W;

  esp_pkg::cfg_t     cfg;
  esp_pkg::rem_req_t rem_req;
  esp_pkg::rem_rsp_t rem_rsp;

  esp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esp_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // sequencer state
  esp_pkg::state_t   state_r, state_nxt;
  esp_pkg::rem_sel_t sel_r, sel_nxt;
  logic [IDXW-1:0]   ch_r, ch_nxt;
  logic              emit_main_r, emit_main_nxt;
  logic              turn_up_r, turn_up_nxt;
  logic              step_neg_r, step_neg_nxt;
  logic              accel_r, accel_nxt;

  // voice state
  logic [esp_pkg::PITCH_W-1:0] main_pitch_r, main_pitch_nxt;
  logic [esp_pkg::PITCH_W-1:0] pitch_r [NCH];
  logic [esp_pkg::PITCH_W-1:0] pitch_nxt [NCH];
  logic [esp_pkg::STEP_W-1:0]  mstep_r [NCH];
  logic [esp_pkg::STEP_W-1:0]  mstep_nxt [NCH];
  logic [esp_pkg::VOL_W-1:0]   vol_r [NCH];
  logic [esp_pkg::VOL_W-1:0]   vol_nxt [NCH];
  logic [esp_pkg::PAN_W-1:0]   pan_r [NCH];
  logic [esp_pkg::PAN_W-1:0]   pan_nxt [NCH];

  // draws of the current tick
  logic [esp_pkg::DRAWS_W-1:0] draws_r [NCH];

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [esp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [esp_pkg::SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                        in_accept;
  logic                        can_load;
  logic                        emit_load;
  logic                        emit_last;
  logic [esp_pkg::PITCH_W-1:0] cur_pitch;
  logic [esp_pkg::STEP_W-1:0]  cur_step;
  logic [esp_pkg::DRAWS_W-1:0] cur_draws;
  logic signed [17:0]          ch_sum;
  logic [16:0]                 main_up;
  logic [9:0]                  step_mag;
  logic [16:0]                 vol_sum;
  logic [esp_pkg::PAN_W-1:0]   pan_sum;
  esp_pkg::rem_sel_t           go_sel;

  function automatic logic [esp_pkg::DRAW_W-1:0] draw_field(
    input logic [esp_pkg::DRAWS_W-1:0] d,
    input esp_pkg::rem_sel_t           s
  );
    logic [esp_pkg::DRAW_W-1:0] f;
    unique case (s)
      esp_pkg::REM_STEP: f = d[esp_pkg::DRAW_W-1:0];
      esp_pkg::REM_VOL:  f = d[2*esp_pkg::DRAW_W-1:esp_pkg::DRAW_W];
      esp_pkg::REM_PAN:  f = d[3*esp_pkg::DRAW_W-1:2*esp_pkg::DRAW_W];
      default:           f = '0;
    endcase
    return f;
  endfunction

  assign in_tready = (state_r == esp_pkg::S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign can_load  = !out_valid_r || out_tready;

  assign cur_pitch = pitch_r[ch_r];
  assign cur_step  = mstep_r[ch_r];
  assign cur_draws = draws_r[ch_r];

  // pitch plus signed step, 18 bits so both overflow directions show
  assign ch_sum  = $signed({2'b00, cur_pitch}) +
                   $signed({{7{cur_step[esp_pkg::STEP_W-1]}}, cur_step});
  assign main_up = {1'b0, main_pitch_r} + {1'b0, cfg.ramp_step};

  // new random values from the remainder
  assign step_mag = {1'b0, rem_rsp.rem[8:0]} + {2'b00, cfg.step_min};
  assign vol_sum  = {1'b0, rem_rsp.rem} + {1'b0, cfg.volume_min};
  assign pan_sum  = rem_rsp.rem[esp_pkg::PAN_W-1:0] + {1'b0, cfg.pan_min};

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    ch_nxt         = ch_r;
    emit_main_nxt  = emit_main_r;
    turn_up_nxt    = turn_up_r;
    step_neg_nxt   = step_neg_r;
    accel_nxt      = accel_r;
    main_pitch_nxt = main_pitch_r;
    pitch_nxt      = pitch_r;
    mstep_nxt      = mstep_r;
    vol_nxt        = vol_r;
    pan_nxt        = pan_r;
    go_sel         = sel_r;
    rem_req.start  = 1'b0;
    emit_load      = 1'b0;
    emit_last      = 1'b0;

    unique case (state_r)
      esp_pkg::S_IDLE: begin
        if (in_accept) begin
          accel_nxt = in_tuser[2];
          // a tick with either enable low is dropped
          if (in_tuser[0] && in_tuser[1]) begin
            state_nxt = esp_pkg::S_MAIN;
          end
        end
      end

      esp_pkg::S_MAIN: begin
        if (accel_r) begin
          main_pitch_nxt = main_up[16] ? esp_pkg::PITCH_MAX : main_up[15:0];
        end else if (main_pitch_r < cfg.ramp_step ||
                     (main_pitch_r - cfg.ramp_step) < cfg.pitch_floor) begin
          main_pitch_nxt = cfg.pitch_floor;
        end else begin
          main_pitch_nxt = main_pitch_r - cfg.ramp_step;
        end
        emit_main_nxt = 1'b1;
        state_nxt     = esp_pkg::S_EMIT;
      end

      esp_pkg::S_CH_EVAL: begin
        priority if (!ch_sum[17] && ch_sum[16]) begin
          // above the ceiling: clamp, draw a new downward step only
          pitch_nxt[ch_r] = esp_pkg::PITCH_MAX;
          step_neg_nxt    = 1'b1;
          turn_up_nxt     = 1'b0;
          rem_req.start   = 1'b1;
          go_sel          = esp_pkg::REM_STEP;
          state_nxt       = esp_pkg::S_REM;
        end else if (ch_sum[17]) begin
          // below zero: clamp and turn upward
          pitch_nxt[ch_r] = '0;
          step_neg_nxt    = 1'b0;
          turn_up_nxt     = 1'b1;
          rem_req.start   = 1'b1;
          go_sel          = esp_pkg::REM_STEP;
          state_nxt       = esp_pkg::S_REM;
        end else begin
          pitch_nxt[ch_r] = ch_sum[15:0];
          if (cur_step[esp_pkg::STEP_W-1] && ch_sum[15:0] < cfg.turn_threshold) begin
            step_neg_nxt  = 1'b0;
            turn_up_nxt   = 1'b1;
            rem_req.start = 1'b1;
            go_sel        = esp_pkg::REM_STEP;
            state_nxt     = esp_pkg::S_REM;
          end else begin
            state_nxt = esp_pkg::S_EMIT;
          end
        end
      end

      esp_pkg::S_REM: begin
        if (rem_rsp.done) begin
          unique case (sel_r)
            esp_pkg::REM_STEP: begin
              mstep_nxt[ch_r] = step_neg_r ? (esp_pkg::STEP_W'(0) - {1'b0, step_mag})
                                           : {1'b0, step_mag};
              if (turn_up_r) begin
                rem_req.start = 1'b1;
                go_sel        = esp_pkg::REM_VOL;
              end else begin
                state_nxt = esp_pkg::S_EMIT;
              end
            end
            esp_pkg::REM_VOL: begin
              vol_nxt[ch_r] = vol_sum[16] ? 16'hFFFF : vol_sum[15:0];
              rem_req.start = 1'b1;
              go_sel        = esp_pkg::REM_PAN;
            end
            esp_pkg::REM_PAN: begin
              pan_nxt[ch_r] = pan_sum;
              state_nxt     = esp_pkg::S_EMIT;
            end
            default: state_nxt = esp_pkg::S_EMIT;
          endcase
        end
      end

      esp_pkg::S_EMIT: begin
        if (can_load) begin
          emit_load = 1'b1;
          if (emit_main_r) begin
            emit_main_nxt = 1'b0;
            ch_nxt        = '0;
            state_nxt     = esp_pkg::S_CH_EVAL;
          end else if (ch_r == IDXW'(NCH - 1)) begin
            emit_last = 1'b1;
            state_nxt = esp_pkg::S_IDLE;
          end else begin
            ch_nxt    = ch_r + IDXW'(1);
            state_nxt = esp_pkg::S_CH_EVAL;
          end
        end
      end

      default: state_nxt = esp_pkg::S_IDLE;
    endcase

    if (rem_req.start) begin
      sel_nxt = go_sel;
    end
  end

  assign rem_req.dividend = draw_field(cur_draws, go_sel);

  always_comb begin
    unique case (go_sel)
      esp_pkg::REM_STEP: rem_req.divisor = esp_pkg::DIV_W'(cfg.step_span);
      esp_pkg::REM_VOL:  rem_req.divisor = cfg.volume_span;
      esp_pkg::REM_PAN:  rem_req.divisor = esp_pkg::PAN_SPAN;
      default:           rem_req.divisor = '0;
    endcase
  end

  // output register load, main voice carries the fixed volume and pan
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    if (can_load) begin
      out_valid_nxt = emit_load;
    end
    if (emit_load) begin
      out_last_nxt = emit_last;
      if (emit_main_r) begin
        out_slot_nxt = '0;
        out_data_nxt = {1'b0, esp_pkg::MAIN_PAN, esp_pkg::MAIN_VOLUME, main_pitch_r};
      end else begin
        out_slot_nxt = esp_pkg::SLOT_W'(ch_r) + esp_pkg::SLOT_W'(1);
        out_data_nxt = {1'b0, pan_r[ch_r], vol_r[ch_r], pitch_r[ch_r]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= esp_pkg::S_IDLE;
      sel_r        <= esp_pkg::REM_STEP;
      ch_r         <= '0;
      emit_main_r  <= 1'b0;
      turn_up_r    <= 1'b0;
      step_neg_r   <= 1'b0;
      accel_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      main_pitch_r <= esp_pkg::RST_MAIN_PITCH;
      for (int i = 0; i < NCH; i++) begin
        pitch_r[i] <= esp_pkg::RST_MOD_PITCH;
        mstep_r[i] <= esp_pkg::RST_MOD_STEP;
        vol_r[i]   <= esp_pkg::RST_MOD_VOLUME;
        pan_r[i]   <= esp_pkg::RST_MOD_PAN;
      end
    end else begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      ch_r         <= ch_nxt;
      emit_main_r  <= emit_main_nxt;
      turn_up_r    <= turn_up_nxt;
      step_neg_r   <= step_neg_nxt;
      accel_r      <= accel_nxt;
      out_valid_r  <= out_valid_nxt;
      main_pitch_r <= main_pitch_nxt;
      pitch_r      <= pitch_nxt;
      mstep_r      <= mstep_nxt;
      vol_r        <= vol_nxt;
      pan_r        <= pan_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < NCH; i++) begin
        draws_r[i] <= in_tdata[i*esp_pkg::DRAWS_W +: esp_pkg::DRAWS_W];
      end
    end
    out_data_r <= out_data_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_slot_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // remainder results only arrive while the sequencer waits for them
  a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> state_r == esp_pkg::S_REM)
    else $error("remainder done outside remainder step");

  // an enabled tick always starts with the main pitch update
  a_tick_starts_main: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] && in_tuser[1]) |=> state_r == esp_pkg::S_MAIN)
    else $error("enabled tick did not start main update");

  // the last update of a tick returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && emit_last) |=> (state_r == esp_pkg::S_IDLE && out_tvalid && out_tlast))
    else $error("last update did not end the tick");

  // decelerating never leaves the main pitch below the floor
  a_floor_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == esp_pkg::S_MAIN && !accel_r) |=> main_pitch_r >= $past(cfg.pitch_floor))
    else $error("main pitch fell below floor");

  // the remainder unit is never restarted while the output is being loaded
  a_no_start_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> !rem_req.start)
    else $error("remainder start during emit");
`endif

endmodule

// File: test/engine_sound_pitch_modulator_test.sv
// self-checking testbench of the engine sound pitch modulator: directed and random frame ticks
`timescale 1ns / 100ps

module engine_sound_pitch_modulator_test;
  import esp_pkg::*;

  // slot code of the main voice, channel voices follow it
  localparam logic [SLOT_W-1:0] SLOT_MAIN_VOICE = 3'd0;

  // drain limit in cycles, and settle time after the last update
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  // receiver hold-off that backs the block up
  localparam int LONG_HOLD   = 400;

  // one frame tick as driven on the input channel
  typedef struct packed {
    logic                             accel;
    logic                             engine_on;
    logic                             audio_ready;
    logic [CH_LIMIT-1:0][DRAWS_W-1:0] draws;
  } tick_t;

  // one voice update as seen on the result channel
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [PITCH_W-1:0] pitch;
    logic [VOL_W-1:0]   volume;
    logic [PAN_W-1:0]   pan;
    logic               last;
  } voice_update_t;

  // register sets, the extremes among them
  localparam cfg_t CFG_BOUNCE = '{
    ramp_step: 16'hFFFF, pitch_floor: 16'hFFFF, turn_threshold: 16'hFFFF,
    step_min: 8'hFF, step_span: 9'h1FF, volume_min: 16'hFFFF,
    volume_span: 16'hFFFF, pan_min: 6'h3F
  };
  localparam cfg_t CFG_FALL = '{
    ramp_step: 16'd3000, pitch_floor: 16'd0, turn_threshold: 16'd0,
    step_min: 8'd0, step_span: 9'd511, volume_min: 16'd1234,
    volume_span: 16'd1, pan_min: 6'd62
  };
  localparam cfg_t CFG_ZERO_SPAN = '{
    ramp_step: 16'd0, pitch_floor: 16'd0, turn_threshold: 16'h8000,
    step_min: 8'd200, step_span: 9'd0, volume_min: 16'd0,
    volume_span: 16'd0, pan_min: 6'd0
  };

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [SLOT_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // predicted state of the block and its registers
  cfg_t                     cfg_live;
  logic [PITCH_W-1:0]       main_pitch_m;
  logic [PITCH_W-1:0]       ch_pitch   [CH_LIMIT];
  logic signed [STEP_W-1:0] ch_step    [CH_LIMIT];
  logic [VOL_W-1:0]         ch_volume  [CH_LIMIT];
  logic [PAN_W-1:0]         ch_pan     [CH_LIMIT];

  voice_update_t pending_voices[$];
  voice_update_t head_voice;
  int            mismatches = 0;

  // idling knobs, percent of cycles
  int src_idle_pct  = 0;
  int rcv_stall_pct = 0;

  // long receiver hold-off: the test bumps hold_seq, the receiver process counts it down
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  engine_sound_pitch_modulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #7_200_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    cfg_live     = CFG_RESET;
    main_pitch_m = RST_MAIN_PITCH;
    for (int ch = 0; ch < CH_LIMIT; ch++) begin
      ch_pitch[ch]  = RST_MOD_PITCH;
      ch_step[ch]   = RST_MOD_STEP;
      ch_volume[ch] = RST_MOD_VOLUME;
      ch_pan[ch]    = RST_MOD_PAN;
    end
  endfunction

  // remainder where a zero modulus gives zero
  function automatic int span_rem(input int value, input int modulus);
    return (modulus == 0) ? 0 : value % modulus;
  endfunction

  // new upward step, volume and pan from this tick's draws
  function automatic void turn_channel_up(input int ch, input logic [DRAWS_W-1:0] d);
    int vol;
    ch_step[ch] = span_rem(d[DRAW_W-1:0], cfg_live.step_span) + cfg_live.step_min;
    vol = span_rem(d[2*DRAW_W-1:DRAW_W], cfg_live.volume_span) + cfg_live.volume_min;
    ch_volume[ch] = (vol > 65535) ? PITCH_MAX : vol[VOL_W-1:0];
    ch_pan[ch] = PAN_W'(span_rem(d[3*DRAW_W-1:2*DRAW_W], PAN_SPAN) + cfg_live.pan_min);
  endfunction

  function automatic void advance_mod_channel(input int ch, input logic [DRAWS_W-1:0] d);
    int step_now;
    int sum;
    step_now = ch_step[ch];
    sum      = int'(ch_pitch[ch]) + step_now;
    if (sum > 65535) begin
      // ceiling: clamp and head down, volume and pan stay
      ch_pitch[ch] = PITCH_MAX;
      ch_step[ch]  = -(span_rem(d[DRAW_W-1:0], cfg_live.step_span) + cfg_live.step_min);
    end else if (sum < 0) begin
      // fell through zero: clamp and turn up whatever the threshold
      ch_pitch[ch] = '0;
      turn_channel_up(ch, d);
    end else begin
      ch_pitch[ch] = sum[PITCH_W-1:0];
      if (step_now < 0 && sum < int'(cfg_live.turn_threshold))
        turn_channel_up(ch, d);
    end
  endfunction

  // advance the predicted state by one accepted tick and queue its voice updates
  function automatic void advance_engine_sound(input tick_t t);
    voice_update_t v;
    logic [PITCH_W:0] up;
    if (!t.audio_ready || !t.engine_on)
      return;
    if (t.accel) begin
      up = main_pitch_m + cfg_live.ramp_step;
      main_pitch_m = up[PITCH_W] ? PITCH_MAX : up[PITCH_W-1:0];
    end else if (main_pitch_m < cfg_live.ramp_step ||
                 main_pitch_m - cfg_live.ramp_step < cfg_live.pitch_floor) begin
      main_pitch_m = cfg_live.pitch_floor;
    end else begin
      main_pitch_m = main_pitch_m - cfg_live.ramp_step;
    end
    for (int ch = 0; ch < CH_COUNT; ch++)
      advance_mod_channel(ch, t.draws[ch]);

    v = '{slot: SLOT_MAIN_VOICE, pitch: main_pitch_m, volume: MAIN_VOLUME,
          pan: MAIN_PAN, last: 1'b0};
    pending_voices.push_back(v);
    for (int ch = 0; ch < CH_COUNT; ch++) begin
      v = '{slot: SLOT_W'(ch + 1), pitch: ch_pitch[ch], volume: ch_volume[ch],
            pan: ch_pan[ch], last: (ch == CH_COUNT - 1)};
      pending_voices.push_back(v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    // keep the log short if everything goes wrong
    if (mismatches <= 60)
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // each voice update taken is held against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_voices.size() == 0) begin
        report_mismatch("voice update with none predicted", 0, out_tdata);
      end else begin
        head_voice = pending_voices.pop_front();
        if (out_tuser !== head_voice.slot)
          report_mismatch("voice_slot", head_voice.slot, out_tuser);
        if (out_tdata[15:0] !== head_voice.pitch)
          report_mismatch("pitch", head_voice.pitch, out_tdata[15:0]);
        if (out_tdata[31:16] !== head_voice.volume)
          report_mismatch("volume", head_voice.volume, out_tdata[31:16]);
        if (out_tdata[38:32] !== head_voice.pan)
          report_mismatch("pan", head_voice.pan, out_tdata[38:32]);
        if (out_tlast !== head_voice.last)
          report_mismatch("last", head_voice.last, out_tlast);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one tick, optionally after an idle gap; valid stays high after the accept edge
  task automatic send_tick(input tick_t t);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tdata  <= {{(IN_TDATA_W - CH_LIMIT * DRAWS_W){1'b0}}, t.draws};
    in_tuser  <= {t.accel, t.engine_on, t.audio_ready};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    advance_engine_sound(t);
  endtask

  // stop offering, wait for every predicted update, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_voices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_voices.size() != 0) begin
      report_mismatch("voice updates never delivered", 0, pending_voices.size());
      pending_voices.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_RAMP_STEP:      cfg_live.ramp_step      = value;
      CFG_PITCH_FLOOR:    cfg_live.pitch_floor    = value;
      CFG_TURN_THRESHOLD: cfg_live.turn_threshold = value;
      CFG_STEP_MIN:       cfg_live.step_min       = value[7:0];
      CFG_STEP_SPAN:      cfg_live.step_span      = value[8:0];
      CFG_VOLUME_MIN:     cfg_live.volume_min     = value;
      CFG_VOLUME_SPAN:    cfg_live.volume_span    = value;
      CFG_PAN_MIN:        cfg_live.pan_min        = value[5:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_RAMP_STEP,      c.ramp_step);
    write_reg(CFG_PITCH_FLOOR,    c.pitch_floor);
    write_reg(CFG_TURN_THRESHOLD, c.turn_threshold);
    write_reg(CFG_STEP_MIN,       CFG_DATA_W'(c.step_min));
    write_reg(CFG_STEP_SPAN,      CFG_DATA_W'(c.step_span));
    write_reg(CFG_VOLUME_MIN,     c.volume_min);
    write_reg(CFG_VOLUME_SPAN,    c.volume_span);
    write_reg(CFG_PAN_MIN,        CFG_DATA_W'(c.pan_min));
  endtask

  // random draws for one channel, each field now and then pinned to an extreme
  function automatic logic [DRAWS_W-1:0] random_draws();
    logic [DRAWS_W-1:0] d;
    d = DRAWS_W'({$urandom, $urandom});
    for (int f = 0; f < 3; f++)
      case ($urandom_range(7))
        0:       d[f*DRAW_W +: DRAW_W] = '0;
        1:       d[f*DRAW_W +: DRAW_W] = '1;
        default: ;
      endcase
    return d;
  endfunction

  function automatic tick_t make_tick(input logic [2:0] flags, input logic [DRAWS_W-1:0] d);
    tick_t t;
    {t.accel, t.engine_on, t.audio_ready} = flags;
    for (int ch = 0; ch < CH_LIMIT; ch++)
      t.draws[ch] = d;
    return t;
  endfunction

  // random ticks until the given number of enabled ones has been taken
  task automatic run_random_ticks(input int enabled_ticks);
    tick_t t;
    int    taken;
    taken = 0;
    while (taken < enabled_ticks) begin
      t.audio_ready = ($urandom_range(19) != 0);
      t.engine_on   = ($urandom_range(19) != 0);
      t.accel       = $urandom_range(1);
      for (int ch = 0; ch < CH_LIMIT; ch++)
        t.draws[ch] = random_draws();
      send_tick(t);
      if (t.audio_ready && t.engine_on)
        taken++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every enable combination, draws at their extremes; decel lands exactly on the floor
  task automatic test_enable_flags();
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    send_tick(make_tick(3'b000, '1));
    send_tick(make_tick(3'b001, '1));
    send_tick(make_tick(3'b010, '0));
    send_tick(make_tick(3'b101, '1));
    send_tick(make_tick(3'b110, '0));
    send_tick(make_tick(3'b100, '1));
    send_tick(make_tick(3'b111, '1));
    send_tick(make_tick(3'b011, '0));
    send_tick(make_tick(3'b011, 45'h0000_7FFF_8000));
    drain_results();
  endtask

  // main pitch saturation, step larger than pitch, and pitch already below the floor
  task automatic test_main_pitch_limits();
    write_reg(CFG_RAMP_STEP, 16'hFFFF);
    send_tick(make_tick(3'b111, 45'h1FFF_C000_7FFF));
    send_tick(make_tick(3'b011, '0));
    send_tick(make_tick(3'b011, '1));
    drain_results();
    write_reg(CFG_RAMP_STEP, 16'd16);
    write_reg(CFG_PITCH_FLOOR, 16'hC000);
    // main pitch sits at 0x2000, under the new floor: decel jumps up to it
    send_tick(make_tick(3'b011, '0));
    send_tick(make_tick(3'b111, '1));
    send_tick(make_tick(3'b011, '0));
    drain_results();
  endtask

  // reset registers and no idling: channels climb from reset until they hit the ceiling
  task automatic test_climb_to_ceiling();
    load_config(CFG_RESET);
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_random_ticks(215);
    drain_results();
  endtask

  // all registers at the top: channels bounce off the ceiling and saturate the volume;
  // midway the receiver holds off so the block fills and stalls its input
  task automatic test_bounce_at_extremes();
    load_config(CFG_BOUNCE);
    src_idle_pct  = 0;
    rcv_stall_pct = 46;
    run_random_ticks(30);
    hold_seq++;
    run_random_ticks(20);
    drain_results();
  endtask

  // no threshold: channels fall all the way and clamp at zero; sender idles, pauses midway
  task automatic test_fall_through_zero();
    load_config(CFG_FALL);
    src_idle_pct  = 46;
    rcv_stall_pct = 0;
    run_random_ticks(70);
    drain_results();
    run_random_ticks(70);
    drain_results();
  endtask

  // zero spans, zero volume and pan minimums: every remainder but the pan one is zero
  task automatic test_zero_spans();
    load_config(CFG_ZERO_SPAN);
    src_idle_pct  = 13;
    rcv_stall_pct = 13;
    run_random_ticks(50);
    drain_results();
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_enable_flags();
    test_main_pitch_limits();
    test_climb_to_ceiling();
    test_bounce_at_extremes();
    test_fall_through_zero();
    test_zero_spans();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
